[design/lumped_resistance_estimate_unit_defines.svh]
// Assertion macros shared by the lumped resistance estimate unit.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LUMPED_RESISTANCE_ESTIMATE_UNIT_DEFINES_SVH
`define LUMPED_RESISTANCE_ESTIMATE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in lumped resistance estimate unit");

// The consequent must hold in the cycle after the antecedent.
`define LRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in lumped resistance estimate unit");

`endif

[design/lre_pkg.sv]
// Types and constants of the lumped resistance estimate unit.
// Used by the front end, the queue, the back end and the top level.
package lre_pkg;

  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int RES_W       = 31;
  localparam int MAG_W       = 31;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [RES_W-1:0] SUM_MAX = 31'h7FFF_FFFF;

  localparam logic [5:0] SQRT_LAST_CNT = 6'd47;
  localparam logic [5:0] DIV_LAST_CNT  = 6'd63;
  localparam logic [5:0] MUL_LAST_CNT  = 6'd30;

  // One classified item as it waits for the back end.
  typedef struct packed {
    logic             active;
    logic [MAG_W-1:0] area;
    logic [MAG_W-1:0] perim;
    logic [RES_W-1:0] res;
    logic             last;
  } lre_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISC,
    ST_SQRT,
    ST_DSET,
    ST_DIV,
    ST_MSET,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } lre_state_t;

  typedef struct packed {
    logic sat_flag;
    logic sum_full;
    logic out_load;
  } lre_status_t;

endpackage

[design/lre_front.sv]
// Front end: holds the sheet resistance registers, classifies each item
// and pushes it into the queue. Depends on lre_pkg.
module lre_front import lre_pkg::*; #(
  parameter int NUM_CLASSES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   s_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [RES_W-1:0]       cfg_data,
  input  logic                   q_full,
  output logic                   push,
  output lre_entry_t             push_entry
);

  logic [RES_W-1:0] sheet_res [NUM_CLASSES];
  logic [2:0]       cls;
  logic [31:0]      area;
  logic [31:0]      perim;
  logic             in_range;
  logic [RES_W-1:0] res_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) sheet_res[i] <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (cfg_index == CFG_INDEX_W'(i)) sheet_res[i] <= cfg_data;
      end
    end
  end

  assign cls      = s_tdata[2:0];
  assign area     = s_tdata[34:3];
  assign perim    = s_tdata[66:35];
  assign in_range = {29'b0, cls} < 32'(NUM_CLASSES);

  always_comb begin
    res_sel = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (cls == 3'(i)) res_sel = sheet_res[i];
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Only items with positive area and perimeter in a known class do work.
  always_comb begin
    push_entry.active = in_range && (area != '0) && !area[31] &&
                        (perim != '0) && !perim[31];
    push_entry.area   = area[MAG_W-1:0];
    push_entry.perim  = perim[MAG_W-1:0];
    push_entry.res    = res_sel;
    push_entry.last   = s_tlast;
  end

endmodule

[design/lre_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on lre_pkg for the entry type.
module lre_queue import lre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lre_entry_t push_entry,
  input  logic       pop,
  output lre_entry_t pop_entry,
  output logic       full,
  output logic       empty
);

  lre_entry_t mem [FIFO_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = count == 2'(FIFO_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[design/lre_back.sv]
// Back end: per active item a square root, a division and, unless the term
// is zero or saturates, a multiply, each one bit per cycle, then the
// saturating node sum and the output register. Depends on lre_pkg.
module lre_back import lre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  lre_entry_t            q_entry,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output lre_status_t           status
);

  lre_state_t       state, state_next;
  logic [MAG_W-1:0] cur_area;
  logic [MAG_W-1:0] cur_perim;
  logic [RES_W-1:0] cur_res;
  logic             cur_last;
  logic [61:0]      pp;
  logic [63:0]      vs;
  logic [50:0]      sq_rem;
  logic [47:0]      root;
  logic [63:0]      dvd;
  logic [47:0]      drem;
  logic [46:0]      den;
  logic [77:0]      acc;
  logic [RES_W-1:0] mres;
  logic [5:0]       cnt;
  logic             term_sat;
  logic [RES_W-1:0] sum;
  logic             sat;
  logic             out_valid;
  logic [RES_W-1:0] out_res;
  logic             out_sat;
  logic             out_load;

  logic [34:0] a16;
  logic [50:0] rem_sh;
  logic [50:0] trial;
  logic        sq_ge;
  logic [46:0] p_fx;
  logic [47:0] dsh;
  logic        div_ge;
  logic [31:0] total;

  assign a16    = {cur_area, 4'b0};
  assign rem_sh = {sq_rem[48:0], vs[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign p_fx   = {cur_perim, 16'b0};
  assign dsh    = {drem[46:0], dvd[63]};
  assign div_ge = dsh >= {1'b0, den};
  assign total  = {1'b0, sum} + {1'b0, acc[46:16]};

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_load = (state == ST_FIN) && cur_last && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) state_next = q_entry.active ? ST_DISC : ST_FIN;
      end
      ST_DISC: state_next = ST_SQRT;
      ST_SQRT: if (cnt == '0) state_next = ST_DSET;
      ST_DSET: state_next = ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_MSET;
      ST_MSET: begin
        if (cur_res == '0 || dvd[63:47] != '0) state_next = ST_ACC;
        else state_next = ST_MUL;
      end
      ST_MUL:  if (cnt == '0) state_next = ST_ACC;
      ST_ACC:  state_next = ST_FIN;
      ST_FIN:  if (!cur_last || out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers; the operands carry no reset.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          cur_area  <= q_entry.area;
          cur_perim <= q_entry.perim;
          cur_res   <= q_entry.res;
          cur_last  <= q_entry.last;
          pp        <= q_entry.perim * q_entry.perim;
        end
      end
      ST_DISC: begin
        vs     <= (pp > 62'(a16)) ? {2'b0, pp - 62'(a16)} : '0;
        sq_rem <= '0;
        root   <= '0;
        cnt    <= SQRT_LAST_CNT;
      end
      ST_SQRT: begin
        sq_rem <= sq_ge ? rem_sh - trial : rem_sh;
        root   <= {root[46:0], sq_ge};
        vs     <= {vs[61:0], 2'b00};
        cnt    <= cnt - 6'd1;
      end
      ST_DSET: begin
        dvd  <= {{1'b0, p_fx} + root, 16'b0};
        den  <= p_fx - root[46:0];
        drem <= '0;
        cnt  <= DIV_LAST_CNT;
      end
      ST_DIV: begin
        drem <= div_ge ? dsh - {1'b0, den} : dsh;
        dvd  <= {dvd[62:0], div_ge};
        cnt  <= cnt - 6'd1;
      end
      ST_MSET: begin
        // A zero sheet resistance adds nothing; a ratio of 2^31 or more
        // with any other resistance always overflows the sum.
        acc      <= '0;
        mres     <= cur_res;
        cnt      <= MUL_LAST_CNT;
        term_sat <= (cur_res != '0) && (dvd[63:47] != '0);
      end
      ST_MUL: begin
        acc  <= {acc[76:0], 1'b0} + (mres[RES_W-1] ? {31'b0, dvd[46:0]} : 78'b0);
        mres <= {mres[RES_W-2:0], 1'b0};
        cnt  <= cnt - 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      sat <= 1'b0;
    end else if (state == ST_ACC) begin
      if (term_sat || acc[77:47] != '0 || total[31]) begin
        sum <= SUM_MAX;
        sat <= 1'b1;
      end else begin
        sum <= total[RES_W-1:0];
      end
    end else if (out_load) begin
      sum <= '0;
      sat <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (m_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= sum;
      out_sat <= sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};
  assign m_tuser  = out_sat;

  always_comb begin
    status.sat_flag = sat;
    status.sum_full = sum == SUM_MAX;
    status.out_load = out_load;
  end

endmodule

[design/lumped_resistance_estimate_unit.sv]
// Lumped resistance estimate of one node: front end, queue and back end.
// Depends on lre_pkg, lre_front, lre_queue, lre_back and the defines header.
//
// Items carry one resistance class each; the item with tlast closes the node
// and produces one result with the saturated sum and its overflow flag in
// tuser. A counted item goes one bit per cycle through a 48-step square root,
// a 64-step restoring divider and, unless its resistance is zero or its ratio
// saturates, a 31-step shift-add multiply. A skipped item goes from idle to
// the finish state. A two-entry queue lets the front end accept while the
// back end works, and the output register holds a result until it is taken.
`include "lumped_resistance_estimate_unit_defines.svh"

module lumped_resistance_estimate_unit import lre_pkg::*; #(
  parameter int NUM_CLASSES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] class_index, [34:3] region_area, [66:35] region_perimeter, rest zero
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [30:0] node_resistance, [31] zero
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // [0] saturated
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [RES_W-1:0]       cfg_data
);

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  lre_entry_t  push_entry;
  lre_entry_t  pop_entry;
  lre_status_t status;

  lre_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_full(q_full), .push(push), .push_entry(push_entry)
  );

  lre_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry),
    .pop(pop), .pop_entry(pop_entry), .full(q_full), .empty(q_empty)
  );

  lre_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_entry(pop_entry), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .status(status)
  );

  `LRE_ASSERT_SAME(a_sat_pins_sum, status.sat_flag, status.sum_full)
  `LRE_ASSERT_SAME(a_out_sat_max, m_tvalid && m_tuser, m_tdata[RES_W-1:0] == SUM_MAX)
  `LRE_ASSERT_NEXT(a_load_shows, status.out_load, m_tvalid)

endmodule

[verif/tb_lumped_resistance_estimate_unit.sv]
// Self-checking testbench for lumped_resistance_estimate_unit.
// Drives class items and sheet resistance writes, and predicts each node result in-house.
// Depends on lre_pkg and the unit's RTL only.
module tb_lumped_resistance_estimate_unit;
  import lre_pkg::*;

  localparam int SHEET_RES_FIRST = 0;
  localparam int SHEET_RES_COUNT = 8;
  localparam int DRAIN_CYCLES    = 400;
  localparam int HOLD_CYCLES     = 1500;

  typedef struct {
    logic [RES_W-1:0] resistance;
    logic             sat;
  } node_result_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tlast;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [RES_W-1:0] cfg_data;

  logic [RES_W-1:0] sheet_res_copy [SHEET_RES_COUNT];
  logic [RES_W-1:0] node_sum;
  logic             node_sat;
  node_result_t     pending_results [$];
  int  mismatches;
  bit  calm;       // no idling on either side while set
  bit  hold_req;   // asks the receiver for one long hold-off

  lumped_resistance_estimate_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("lumped_resistance_estimate_unit: mismatch");
    $finish;
  end

  // Truncated term: (P + S) / (P - S) in 16 fractional bits, times the sheet resistance.
  function automatic logic [127:0] class_term(logic [31:0] area, logic [31:0] perim,
                                              logic [RES_W-1:0] res);
    logic [127:0] pp, a16, disc, scaled, root, cand, num, den, q, r, f;
    pp = perim * perim;
    a16 = area << 4;
    disc = (pp > a16) ? pp - a16 : 0;
    scaled = disc << 32;
    root = 0;
    for (int b = 47; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= scaled) root = cand;
    end
    num = (perim << 16) + root;
    den = (perim << 16) - root;
    if (den == 0) den = 1;
    q = num / den;
    r = num % den;
    f = (r << 16) / den;
    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
    return q * res + ((f * res) >> 16);
  endfunction

  function automatic void accumulate(logic [2:0] cls, logic [31:0] area,
                                     logic [31:0] perim, logic last);
    logic [127:0] term;
    node_result_t res;
    if (!area[31] && area != 0 && !perim[31] && perim != 0) begin
      term = class_term(area, perim, sheet_res_copy[cls]);
      if (term > SUM_MAX || term + node_sum > SUM_MAX) begin
        node_sum = SUM_MAX;
        node_sat = 1;
      end else begin
        node_sum = node_sum + term[RES_W-1:0];
      end
    end
    if (last) begin
      res.resistance = node_sum;
      res.sat = node_sat;
      pending_results.push_back(res);
      node_sum = 0;
      node_sat = 0;
    end
  endfunction

  task automatic report(string what);
    mismatches++;
    $display("error at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    node_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report("result with none expected");
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[RES_W-1:0] !== want.resistance)
          report($sformatf("node_resistance %0d, expected %0d",
                           m_tdata[RES_W-1:0], want.resistance));
        if (m_tdata[OUT_DATA_W-1] !== 1'b0) report("tdata pad bit set");
        if (m_tuser !== want.sat)
          report($sformatf("saturated %0b, expected %0b", m_tuser, want.sat));
      end
    end
  end

  // Receiver: random stalls, plus one counted hold-off on request.
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 0;
      end
      m_tready = calm || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic send_item(logic [2:0] cls, logic [31:0] area, logic [31:0] perim,
                           logic last);
    if (!calm && $urandom_range(0, 99) < 15) begin
      @(negedge clk);
      s_tvalid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tdata = '0;
    s_tdata[2:0] = cls;
    s_tdata[34:3] = area;
    s_tdata[66:35] = perim;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    accumulate(cls, area, perim, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sheet_res(int idx, logic [RES_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = CFG_INDEX_W'(idx);
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sheet_res_copy[cfg_index] = value;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic load_all_sheet_res(int mode);
    logic [RES_W-1:0] v;
    for (int i = 0; i < SHEET_RES_COUNT; i++) begin
      case (mode)
        0: v = '0;
        1: v = SUM_MAX;
        2: v = RES_W'($urandom_range(1, 5000));
        default: v = RES_W'($urandom);
      endcase
      write_sheet_res(SHEET_RES_FIRST + i, v);
    end
  endtask

  function automatic logic [31:0] pick_dim(bit small_bias);
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      4, 5: return $urandom_range(1, 32'h000F_FFFF);
      default: return small_bias ? $urandom_range(1, 64) : $urandom_range(1, 4000);
    endcase
  endfunction

  task automatic test_directed();
    load_all_sheet_res(2);
    send_item(0, 1, 1, 1);                        // disc negative, ratio one
    send_item(1, 100, 4, 1);                      // area swamps perimeter
    send_item(2, 1, 32'h7FFF_FFFF, 1);            // huge ratio
    send_item(3, 0, 10, 0);                       // skipped: zero area
    send_item(4, 10, 0, 0);                       // skipped: zero perimeter
    send_item(5, 32'h8000_0000, 10, 0);           // skipped: negative area
    send_item(6, 10, 32'hFFFF_FFFF, 1);           // skipped last still reports
    send_item(7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_item(7, 24, 20, 1);
    wait_idle();
    load_all_sheet_res(1);
    send_item(0, 16, 16, 0);                      // sum overflow
    send_item(1, 16, 16, 0);
    send_item(2, 0, 0, 1);
    send_item(0, 1, 1, 1);
    wait_idle();
    load_all_sheet_res(0);
    send_item(3, 1, 32'h7FFF_FFFF, 1);            // huge ratio with zero sheet resistance
    send_item(4, 5, 9, 1);
    wait_idle();
  endtask

  task automatic test_random(int count, int mode);
    load_all_sheet_res(mode);
    for (int i = 0; i < count; i++)
      send_item(3'($urandom_range(0, 7)), pick_dim(0), pick_dim(1),
                $urandom_range(0, 3) == 0);
    send_item(3'($urandom_range(0, 7)), pick_dim(0), pick_dim(1), 1);
    wait_idle();
  endtask

  task automatic test_calm_stretch();
    calm = 1;
    test_random(120, 3);
    calm = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 40; i++)
      send_item(3'($urandom_range(0, 7)), $urandom_range(1, 50), $urandom_range(1, 200), 1);
    wait_idle();
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    calm = 0; hold_req = 0; mismatches = 0;
    node_sum = 0; node_sat = 0;
    foreach (sheet_res_copy[i]) sheet_res_copy[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random(250, 2);
    test_random(250, 3);
    test_calm_stretch();
    test_backpressure();
    test_random(200, 1);
    test_random(150, 0);
    test_random(150, 2);
    if (mismatches == 0)
      $display("lumped_resistance_estimate_unit: match");
    else
      $display("lumped_resistance_estimate_unit: mismatch");
    $finish;
  end
endmodule
